// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk_i, off while in reset
`define SSBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// implication form of the above
`define SSBP_ASSERT_IMP(lbl, pre, post, msg) \
  `SSBP_ASSERT(lbl, (pre) |-> (post), msg)

`endif

// File: hw/rtl/ssbp_pkg.sv
`default_nettype none
package ssbp_pkg;

  localparam int MaxItemsDef = 128;
  localparam int MaxSumDef   = 4096;
  localparam int SizeBitsDef = 7;

  localparam int WordBits = 64;
  localparam int ShBits   = 6;

  localparam int FuncW   = 2;
  localparam int InSizeW = 7;
  localparam int InIdxW  = 7;
  localparam int CapW    = 12;
  localparam int StatusW = 2;
  localparam int BestW   = 12;
  localparam int ChosenW = 8;
  localparam int SolveW  = 3;

  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_SOLVE = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusRange = 2'd2;

endpackage
`default_nettype wire

// File: hw/rtl/ssbp_ram.sv
`default_nettype none
module ssbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: hw/rtl/ssbp_word_unit.sv
`default_nettype none
module ssbp_word_unit
  import ssbp_pkg::*;
(
  input  wire logic [WordBits-1:0] prev_i,
  input  wire logic [WordBits-1:0] lo_i,
  input  wire logic [WordBits-1:0] hi_i,
  input  wire logic [ShBits-1:0]   sh_i,
  output      logic [WordBits-1:0] word_o
);

  logic [ShBits:0]       rsh;
  logic [WordBits-1:0]   carry;

  // lo_i is the word at w-k, hi_i the one below it
  always_comb begin
    rsh    = (ShBits+1)'(WordBits) - {1'b0, sh_i};
    carry  = (sh_i == '0) ? '0 : (hi_i >> rsh);
    word_o = prev_i | (lo_i << sh_i) | carry;
  end

endmodule
`default_nettype wire

// File: hw/rtl/subset_sum_block_packer.sv
// Subset-sum block packer. Load words append item sizes; a solve word builds a
// reachability table over the still-free items up to the capacity (clamped to
// MAX_SUM-1), returns the largest reachable sum and marks the chosen items with
// the solve number; query words return owner of an item; clear forgets all.
// One word is taken at a time and in_ready_o is low until its result is
// registered. The table sweep steps through states S_F0 to S_F3 for each
// 64-bit word written, as the reach memory has one read port and each word
// needs three reads.
`default_nettype none
`include "assert_macros.svh"
module subset_sum_block_packer
  import ssbp_pkg::*;
#(
  parameter int MAX_ITEMS = MaxItemsDef,
  parameter int MAX_SUM   = MaxSumDef,
  parameter int SIZE_BITS = SizeBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [FuncW-1:0]   func_i,
  input  wire logic [InSizeW-1:0] item_size_i,
  input  wire logic [InIdxW-1:0]  item_index_i,
  input  wire logic [CapW-1:0]    capacity_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [StatusW-1:0] status_o,
  output      logic [BestW-1:0]   best_sum_o,
  output      logic [ChosenW-1:0] chosen_count_o,
  output      logic               item_taken_o,
  output      logic [SolveW-1:0]  taken_by_o
);

  localparam int IdxW     = $clog2(MAX_ITEMS);
  localparam int CntW     = $clog2(MAX_ITEMS + 1);
  localparam int SumW     = $clog2(MAX_SUM);
  localparam int RowWords = (MAX_SUM + WordBits - 1) / WordBits;
  localparam int WB       = (RowWords > 1) ? $clog2(RowWords) : 1;
  localparam int KW       = ((WB > SIZE_BITS) ? WB : SIZE_BITS) + 2;
  localparam int CW       = (SumW > CapW) ? SumW : CapW;
  localparam int QW       = (CntW > InIdxW) ? CntW : InIdxW;
  localparam int FreeW    = IdxW + SIZE_BITS;
  localparam int ReachD   = MAX_ITEMS * (2 ** WB);
  localparam int ReachAW  = $clog2(ReachD);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PUSH  = 5'd1;
  localparam logic [4:0] S_QRY   = 5'd2;
  localparam logic [4:0] S_SCAN0 = 5'd3;
  localparam logic [4:0] S_SCAN1 = 5'd4;
  localparam logic [4:0] S_ROW   = 5'd5;
  localparam logic [4:0] S_ROWSZ = 5'd6;
  localparam logic [4:0] S_F0    = 5'd7;
  localparam logic [4:0] S_F1    = 5'd8;
  localparam logic [4:0] S_F2    = 5'd9;
  localparam logic [4:0] S_F3    = 5'd10;
  localparam logic [4:0] S_FD0   = 5'd11;
  localparam logic [4:0] S_FD1   = 5'd12;
  localparam logic [4:0] S_BT0   = 5'd13;
  localparam logic [4:0] S_BT1   = 5'd14;
  localparam logic [4:0] S_BT2   = 5'd15;
  localparam logic [4:0] S_BT3   = 5'd16;

  logic [4:0]           state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [SolveW-1:0]    solve_q, solve_d;
  logic [MAX_ITEMS-1:0] taken_q, taken_d;
  logic [CntW-1:0]      i_q, i_d, n_q, n_d, r_q, r_d, chosen_q, chosen_d;
  logic [SumW-1:0]      cap_q, cap_d, s_q, s_d, best_q, best_d;
  logic [SIZE_BITS-1:0] sz_q, sz_d;
  logic [WB-1:0]        w_q, w_d;
  logic [WordBits-1:0]  a_q, a_d, b_q, b_d;
  logic [IdxW-1:0]      qidx_q, qidx_d;

  logic [StatusW-1:0] res_status_q, res_status_d;
  logic [BestW-1:0]   res_best_q, res_best_d;
  logic [ChosenW-1:0] res_chosen_q, res_chosen_d;
  logic               res_taken_q, res_taken_d;
  logic [SolveW-1:0]  res_by_q, res_by_d;
  logic               out_valid_q, out_valid_d;

  logic                 size_we;
  logic [IdxW-1:0]      size_waddr, size_raddr;
  logic [SIZE_BITS-1:0] size_wdata, size_rdata;
  logic                 own_we;
  logic [IdxW-1:0]      own_waddr, own_raddr;
  logic [SolveW-1:0]    own_rdata;
  logic                 free_we;
  logic [IdxW-1:0]      free_waddr, free_raddr;
  logic [FreeW-1:0]     free_wdata, free_rdata;
  logic                 reach_we;
  logic [ReachAW-1:0]   reach_waddr, reach_raddr;
  logic [WordBits-1:0]  reach_wdata, reach_rdata;

  logic [KW-1:0]        wx, kx, wk, wk1;
  logic                 first_row, lo_neg, hi_neg;
  logic [WordBits-1:0]  c_word;
  logic [IdxW-1:0]      prev_row, bt_row;
  logic [CW-1:0]        cap_ext;
  logic [QW-1:0]        qidx_ext, qcnt_ext;
  logic [IdxW-1:0]      bt_item;
  logic [SIZE_BITS-1:0] bt_size;
  logic [SumW-1:0]      s_sub;

  ssbp_ram #(.Width(SIZE_BITS), .Depth(MAX_ITEMS)) u_size_ram (
    .clk_i, .we_i(size_we), .waddr_i(size_waddr), .wdata_i(size_wdata),
    .raddr_i(size_raddr), .rdata_o(size_rdata)
  );

  ssbp_ram #(.Width(SolveW), .Depth(MAX_ITEMS)) u_owner_ram (
    .clk_i, .we_i(own_we), .waddr_i(own_waddr), .wdata_i(solve_q),
    .raddr_i(own_raddr), .rdata_o(own_rdata)
  );

  ssbp_ram #(.Width(FreeW), .Depth(MAX_ITEMS)) u_free_ram (
    .clk_i, .we_i(free_we), .waddr_i(free_waddr), .wdata_i(free_wdata),
    .raddr_i(free_raddr), .rdata_o(free_rdata)
  );

  ssbp_ram #(.Width(WordBits), .Depth(ReachD)) u_reach_ram (
    .clk_i, .we_i(reach_we), .waddr_i(reach_waddr), .wdata_i(reach_wdata),
    .raddr_i(reach_raddr), .rdata_o(reach_rdata)
  );

  always_comb begin
    wx        = KW'(w_q);
    kx        = KW'(sz_q >> ShBits);
    wk        = wx - kx;
    wk1       = wk - KW'(1);
    lo_neg    = kx > wx;
    hi_neg    = (kx + KW'(1)) > wx;
    first_row = (r_q == CntW'(1));
    prev_row  = IdxW'(r_q - CntW'(2));
    bt_row    = IdxW'(r_q - CntW'(2));
    if (hi_neg) begin
      c_word = '0;
    end else if (first_row) begin
      c_word = (wk1 == '0) ? WordBits'(1) : '0;
    end else begin
      c_word = reach_rdata;
    end
    cap_ext  = CW'(capacity_i);
    qidx_ext = QW'(item_index_i);
    qcnt_ext = QW'(count_q);
    bt_item  = free_rdata[FreeW-1:SIZE_BITS];
    bt_size  = free_rdata[SIZE_BITS-1:0];
    s_sub    = s_q - SumW'(bt_size);
  end

  ssbp_word_unit u_word_unit (
    .prev_i(a_q), .lo_i(b_q), .hi_i(c_word), .sh_i(ShBits'(sz_q)),
    .word_o(reach_wdata)
  );

  always_comb begin
    size_we     = 1'b0;
    size_waddr  = count_q[IdxW-1:0];
    size_wdata  = SIZE_BITS'(item_size_i);
    size_raddr  = i_q[IdxW-1:0];
    own_we      = 1'b0;
    own_waddr   = bt_item;
    own_raddr   = IdxW'(item_index_i);
    free_we     = 1'b0;
    free_waddr  = n_q[IdxW-1:0];
    free_wdata  = {i_q[IdxW-1:0], size_rdata};
    free_raddr  = IdxW'(r_q - CntW'(1));
    reach_we    = 1'b0;
    reach_waddr = {IdxW'(r_q - CntW'(1)), w_q};
    reach_raddr = {prev_row, w_q};

    state_d  = state_q;
    count_d  = count_q;
    solve_d  = solve_q;
    taken_d  = taken_q;
    i_d      = i_q;
    n_d      = n_q;
    r_d      = r_q;
    chosen_d = chosen_q;
    cap_d    = cap_q;
    s_d      = s_q;
    best_d   = best_q;
    sz_d     = sz_q;
    w_d      = w_q;
    a_d      = a_q;
    b_d      = b_q;
    qidx_d   = qidx_q;

    res_status_d = res_status_q;
    res_best_d   = res_best_q;
    res_chosen_d = res_chosen_q;
    res_taken_d  = res_taken_q;
    res_by_d     = res_by_q;
    out_valid_d  = out_valid_q & ~out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = StatusOk;
          res_best_d   = '0;
          res_chosen_d = '0;
          res_taken_d  = 1'b0;
          res_by_d     = '0;
          state_d      = S_PUSH;
          unique case (func_e'(func_i))
            FUNC_LOAD: begin
              if (count_q >= CntW'(MAX_ITEMS)) begin
                res_status_d = StatusFull;
              end else begin
                size_we                   = 1'b1;
                taken_d[count_q[IdxW-1:0]] = 1'b0;
                count_d                   = count_q + CntW'(1);
              end
            end
            FUNC_SOLVE: begin
              cap_d    = (cap_ext > CW'(MAX_SUM - 1)) ? SumW'(MAX_SUM - 1) : SumW'(cap_ext);
              i_d      = '0;
              n_d      = '0;
              r_d      = CntW'(1);
              chosen_d = '0;
              state_d  = (count_q == '0) ? S_ROW : S_SCAN0;
            end
            FUNC_QUERY: begin
              if (qidx_ext >= qcnt_ext) begin
                res_status_d = StatusRange;
              end else begin
                qidx_d  = IdxW'(item_index_i);
                state_d = S_QRY;
              end
            end
            FUNC_CLEAR: begin
              taken_d = '0;
              count_d = '0;
              solve_d = '0;
              n_d     = '0;
            end
            default: ;
          endcase
        end
      end
      S_QRY: begin
        res_taken_d = taken_q[qidx_q];
        res_by_d    = taken_q[qidx_q] ? own_rdata : '0;
        state_d     = S_PUSH;
      end
      S_SCAN0: begin
        state_d = S_SCAN1;
      end
      S_SCAN1: begin
        if (!taken_q[i_q[IdxW-1:0]]) begin
          free_we = 1'b1;
          n_d     = n_q + CntW'(1);
        end
        i_d     = i_q + CntW'(1);
        state_d = (i_d == count_q) ? S_ROW : S_SCAN0;
      end
      S_ROW: begin
        if (r_q > n_q) begin
          if (n_q == '0) begin
            best_d  = '0;
            s_d     = '0;
            r_d     = '0;
            state_d = S_BT0;
          end else begin
            s_d     = cap_q;
            state_d = S_FD0;
          end
        end else begin
          state_d = S_ROWSZ;
        end
      end
      S_ROWSZ: begin
        sz_d    = bt_size;
        w_d     = '0;
        state_d = S_F0;
      end
      S_F0: begin
        state_d = S_F1;
      end
      S_F1: begin
        reach_raddr = {prev_row, WB'(wk)};
        if (first_row) begin
          a_d = (w_q == '0) ? WordBits'(1) : '0;
        end else begin
          a_d = reach_rdata;
        end
        state_d = S_F2;
      end
      S_F2: begin
        reach_raddr = {prev_row, WB'(wk1)};
        if (lo_neg) begin
          b_d = '0;
        end else if (first_row) begin
          b_d = (wk == '0) ? WordBits'(1) : '0;
        end else begin
          b_d = reach_rdata;
        end
        state_d = S_F3;
      end
      S_F3: begin
        reach_we = 1'b1;
        if (w_q == WB'(cap_q >> ShBits)) begin
          r_d     = r_q + CntW'(1);
          state_d = S_ROW;
        end else begin
          w_d     = w_q + WB'(1);
          state_d = S_F0;
        end
      end
      S_FD0: begin
        reach_raddr = {IdxW'(n_q - CntW'(1)), WB'(s_q >> ShBits)};
        state_d     = S_FD1;
      end
      S_FD1: begin
        if (reach_rdata[ShBits'(s_q)] || (s_q == '0)) begin
          best_d  = s_q;
          r_d     = n_q;
          state_d = S_BT0;
        end else begin
          s_d     = s_q - SumW'(1);
          state_d = S_FD0;
        end
      end
      S_BT0: begin
        reach_raddr = {bt_row, WB'(s_q >> ShBits)};
        if ((r_q == '0) || (s_q == '0)) begin
          res_best_d   = BestW'(best_q);
          res_chosen_d = ChosenW'(chosen_q);
          solve_d      = solve_q + SolveW'(1);
          state_d      = S_PUSH;
        end else if (first_row) begin
          state_d = S_BT2;
        end else begin
          state_d = S_BT1;
        end
      end
      S_BT1: begin
        if (reach_rdata[ShBits'(s_q)]) begin
          r_d     = r_q - CntW'(1);
          state_d = S_BT0;
        end else begin
          state_d = S_BT2;
        end
      end
      S_BT2: begin
        state_d = S_BT3;
      end
      S_BT3: begin
        own_we           = 1'b1;
        taken_d[bt_item] = 1'b1;
        s_d              = s_sub;
        chosen_d         = chosen_q + CntW'(1);
        r_d              = r_q - CntW'(1);
        state_d          = S_BT0;
      end
      S_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      solve_q     <= '0;
      taken_q     <= '0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      n_q         <= '0;
      r_q         <= '0;
      chosen_q    <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      solve_q     <= solve_d;
      taken_q     <= taken_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      n_q         <= n_d;
      r_q         <= r_d;
      chosen_q    <= chosen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_q        <= cap_d;
    s_q          <= s_d;
    best_q       <= best_d;
    sz_q         <= sz_d;
    w_q          <= w_d;
    a_q          <= a_d;
    b_q          <= b_d;
    qidx_q       <= qidx_d;
    res_status_q <= res_status_d;
    res_best_q   <= res_best_d;
    res_chosen_q <= res_chosen_d;
    res_taken_q  <= res_taken_d;
    res_by_q     <= res_by_d;
    if ((state_q == S_PUSH) && (!out_valid_q || out_ready_i)) begin
      status_o       <= res_status_q;
      best_sum_o     <= res_best_q;
      chosen_count_o <= res_chosen_q;
      item_taken_o   <= res_taken_q;
      taken_by_o     <= res_by_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `SSBP_ASSERT(a_one_word, (in_valid_i && in_ready_o) |=> !in_ready_o, "word taken while busy")
  `SSBP_ASSERT(a_count_max, count_q <= CntW'(MAX_ITEMS), "item count past table size")
  `SSBP_ASSERT_IMP(a_free_le_count, state_q != S_IDLE, n_q <= count_q, "free list too long")

endmodule
`default_nettype wire
